FILE: rtl/sdp_pkg.sv
// Shared types and constants for the spring direction projection block.
package sdp_pkg;

	localparam int unsigned MaxEdges = 65536;
	// The tag is exactly as wide as the edge count needs, so it wraps by itself.
	localparam int unsigned TagW = $clog2(MaxEdges);
	localparam int unsigned CoordW = 32;
	localparam int unsigned RestW = 31;
	localparam int unsigned MagW = 33;
	localparam int unsigned NormW = 31;
	localparam int unsigned SqW = 64;
	localparam int unsigned RootW = 32;
	localparam int unsigned NumW = 62;
	localparam int unsigned QuoW = 32;
	// One square-root cell resolves one result bit.
	localparam int unsigned SqrtCells = 32;
	// One divider cell resolves one quotient bit.
	localparam int unsigned DivCells = 32;

	typedef struct packed {
		logic [TagW-1:0] tag;
		logic            degen;
		logic [2:0]      neg;
	} side_t;

	// Normalisation shift: positive means shift left, negative means right.
	function automatic logic signed [6:0] norm_shift(input logic [MagW-1:0] mx);
		logic signed [6:0] sh;
		sh = 7'sd0;
		for (int i = 0; i < MagW; i++) begin
			if (mx[i]) begin
				sh = 7'(30 - i);
			end
		end
		return sh;
	endfunction

endpackage

FILE: rtl/spring_direction_projection.sv
// Top level of the spring direction projection pipeline.
//  channel | signals                                           | role
//  in      | valid ready edge_tag p_* q_* rest_length          | one spring
//  out     | out_valid out_ready out_edge_tag dir_* degenerate | projected vector
// One spring is taken every cycle unless the output stalls; a result passes through
// the four front stages, the square-root chain, the three divider chains (each cell
// resolving one bit) and the output register.
// The whole pipeline advances only when the output register is free or being taken,
// so a stall at the output holds every stage.
// Reset clears the valid bits only; payload registers are not reset.
module spring_direction_projection (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       valid,
	output logic                       ready,
	input  logic [sdp_pkg::TagW-1:0]   edge_tag,
	input  logic signed [sdp_pkg::CoordW-1:0] p_x,
	input  logic signed [sdp_pkg::CoordW-1:0] p_y,
	input  logic signed [sdp_pkg::CoordW-1:0] p_z,
	input  logic signed [sdp_pkg::CoordW-1:0] q_x,
	input  logic signed [sdp_pkg::CoordW-1:0] q_y,
	input  logic signed [sdp_pkg::CoordW-1:0] q_z,
	input  logic [sdp_pkg::RestW-1:0]  rest_length,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [sdp_pkg::TagW-1:0]   out_edge_tag,
	output logic signed [sdp_pkg::CoordW-1:0] dir_x,
	output logic signed [sdp_pkg::CoordW-1:0] dir_y,
	output logic signed [sdp_pkg::CoordW-1:0] dir_z,
	output logic                       degenerate
);
	import sdp_pkg::*;

	localparam int unsigned Depth = 4 + SqrtCells + DivCells;

	logic adv;
	logic [Depth-1:0] vld_q;

	assign adv   = !out_valid || out_ready;
	assign ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			out_valid <= 1'b0;
		end else if (adv) begin
			vld_q     <= {vld_q[Depth-2:0], valid};
			out_valid <= vld_q[Depth-1];
		end
	end

	// Stage 1: differences and magnitudes.
	logic [MagW-1:0] m_s1 [3];
	logic [RestW-1:0] rest_s1;
	side_t side_s1;
	logic [MagW-1:0] mx_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			logic signed [MagW-1:0] d [3];
			d[0] = MagW'(p_x) - MagW'(q_x);
			d[1] = MagW'(p_y) - MagW'(q_y);
			d[2] = MagW'(p_z) - MagW'(q_z);
			for (int k = 0; k < 3; k++) begin
				m_s1[k]        <= d[k][MagW-1] ? MagW'(-d[k]) : MagW'(d[k]);
				side_s1.neg[k] <= d[k][MagW-1];
			end
			side_s1.tag   <= edge_tag;
			side_s1.degen <= 1'b0;
			rest_s1       <= rest_length;
		end
	end

	// Stage 2: maximum and shift amount.
	logic [MagW-1:0] m_s2 [3];
	logic [RestW-1:0] rest_s2;
	side_t side_s2;
	logic signed [6:0] sh_s2;

	always_comb begin
		mx_s1 = m_s1[0];
		if (m_s1[1] > mx_s1) mx_s1 = m_s1[1];
		if (m_s1[2] > mx_s1) mx_s1 = m_s1[2];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_s2    <= m_s1;
			rest_s2 <= rest_s1;
			side_s2 <= '{tag: side_s1.tag, degen: (mx_s1 == '0), neg: side_s1.neg};
			sh_s2   <= norm_shift(mx_s1);
		end
	end

	// Stage 3: normalise.
	logic [NormW-1:0] n_s3 [3];
	logic [RestW-1:0] rest_s3;
	side_t side_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				if (sh_s2 < 0) begin
					n_s3[k] <= NormW'(m_s2[k] >> 7'(-sh_s2));
				end else begin
					n_s3[k] <= NormW'(m_s2[k] << sh_s2);
				end
			end
			rest_s3 <= rest_s2;
			side_s3 <= side_s2;
		end
	end

	// Stage 4: squares and their sum (products are 62 bits).
	logic [2*NormW-1:0] sqp [3];
	logic [SqW-1:0] sq_s4;
	logic [NormW-1:0] n_s4 [3];
	logic [RestW-1:0] rest_s4;
	side_t side_s4;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sqp[k] = n_s3[k] * n_s3[k];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s4   <= SqW'(sqp[0]) + SqW'(sqp[1]) + SqW'(sqp[2]);
			n_s4    <= n_s3;
			rest_s4 <= rest_s3;
			side_s4 <= side_s3;
		end
	end

	// Square-root chain; side data rides alongside in delay lines.
	logic [SqW-1:0]   sr_rem  [SqrtCells+1];
	logic [RootW-1:0] sr_root [SqrtCells+1];
	logic [SqW-1:0]   sr_s    [SqrtCells+1];
	logic [NormW-1:0] dl_n    [SqrtCells+1][3];
	logic [RestW-1:0] dl_rest [SqrtCells+1];
	side_t            dl_side [SqrtCells+1];

	assign sr_rem[0]  = '0;
	assign sr_root[0] = '0;
	assign sr_s[0]    = sq_s4;
	assign dl_n[0]    = n_s4;
	assign dl_rest[0] = rest_s4;
	assign dl_side[0] = side_s4;

	for (genvar i = 0; i < SqrtCells; i++) begin : g_sqrt
		sdp_sqrt_cell u_cell (
			.clk      (clk),
			.en       (adv),
			.rem_in   (sr_rem[i]),
			.root_in  (sr_root[i]),
			.s_in     (sr_s[i]),
			.pos      (6'(SqrtCells - 1 - i)),
			.rem_out  (sr_rem[i+1]),
			.root_out (sr_root[i+1]),
			.s_out    (sr_s[i+1])
		);
		always_ff @(posedge clk) begin
			if (adv) begin
				dl_n[i+1]    <= dl_n[i];
				dl_rest[i+1] <= dl_rest[i];
				dl_side[i+1] <= dl_side[i];
			end
		end
	end

	// Numerators: rest * n + floor(den/2), widened by one bit so the sum cannot overflow.
	logic [RootW-1:0] den;
	logic [NumW-1:0]  prod  [3];
	logic [NumW:0]    numer [3];
	always_comb begin
		den = (sr_root[SqrtCells] == '0) ? RootW'(1) : sr_root[SqrtCells];
		for (int k = 0; k < 3; k++) begin
			prod[k]  = dl_rest[SqrtCells] * dl_n[SqrtCells][k];
			numer[k] = (NumW+1)'(prod[k]) + (NumW+1)'(den >> 1);
		end
	end

	// The numerator is below 2^62 and the quotient below 2^32 since each n is at most the root.
	logic [RootW:0]   dv_rem [3][DivCells+1];
	logic [NumW-1:0]  dv_num [3][DivCells+1];
	logic [RootW-1:0] dv_den [3][DivCells+1];
	logic [QuoW-1:0]  dv_quo [3][DivCells+1];
	side_t            dv_side [DivCells+1];

	assign dv_side[0] = dl_side[SqrtCells];

	for (genvar k = 0; k < 3; k++) begin : g_lane
		// Upper numerator bits above the quotient range form the starting remainder.
		assign dv_rem[k][0] = (RootW+1)'(numer[k][NumW:DivCells]);
		assign dv_num[k][0] = NumW'(numer[k]);
		assign dv_den[k][0] = den;
		assign dv_quo[k][0] = '0;
		for (genvar i = 0; i < DivCells; i++) begin : g_div
			sdp_div_cell u_cell (
				.clk     (clk),
				.en      (adv),
				.pos     (6'(DivCells - 1 - i)),
				.rem_in  (dv_rem[k][i]),
				.num_in  (dv_num[k][i]),
				.den_in  (dv_den[k][i]),
				.quo_in  (dv_quo[k][i]),
				.rem_out (dv_rem[k][i+1]),
				.num_out (dv_num[k][i+1]),
				.den_out (dv_den[k][i+1]),
				.quo_out (dv_quo[k][i+1])
			);
		end
	end

	for (genvar i = 0; i < DivCells; i++) begin : g_side
		always_ff @(posedge clk) begin
			if (adv) begin
				dv_side[i+1] <= dv_side[i];
			end
		end
	end

	// Output register: saturate, apply sign, force zero for coincident endpoints.
	function automatic logic [CoordW-1:0] finish(input logic [QuoW-1:0] q,
			input logic neg, input logic degen);
		logic [CoordW-1:0] mag;
		mag = q[QuoW-1] ? CoordW'(32'h7FFF_FFFF) : CoordW'(q);
		if (degen) return '0;
		return neg ? CoordW'(-mag) : mag;
	endfunction

	always_ff @(posedge clk) begin
		if (adv) begin
			out_edge_tag <= dv_side[DivCells].tag;
			degenerate   <= dv_side[DivCells].degen;
			dir_x <= finish(dv_quo[0][DivCells], dv_side[DivCells].neg[0],
				dv_side[DivCells].degen);
			dir_y <= finish(dv_quo[1][DivCells], dv_side[DivCells].neg[1],
				dv_side[DivCells].degen);
			dir_z <= finish(dv_quo[2][DivCells], dv_side[DivCells].neg[2],
				dv_side[DivCells].degen);
		end
	end
endmodule

FILE: rtl/sdp_sqrt_cell.sv
// One cell of the restoring square-root chain: resolves one root bit per stage.
module sdp_sqrt_cell (
	input  logic                      clk,
	input  logic                      en,
	input  logic [sdp_pkg::SqW-1:0]   rem_in,
	input  logic [sdp_pkg::RootW-1:0] root_in,
	input  logic [sdp_pkg::SqW-1:0]   s_in,
	input  logic [5:0]                pos,
	output logic [sdp_pkg::SqW-1:0]   rem_out,
	output logic [sdp_pkg::RootW-1:0] root_out,
	output logic [sdp_pkg::SqW-1:0]   s_out
);
	import sdp_pkg::*;

	logic [SqW+1:0] rem_shift;
	logic [SqW+1:0] trial;
	logic           take;

	// Bring down the next two radicand bits and try root*4+1.
	always_comb begin
		rem_shift = {rem_in, s_in[2*pos+1 -: 2]};
		trial     = {root_in, 2'b01};
		take      = rem_shift >= trial;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_out  <= take ? SqW'(rem_shift - trial) : SqW'(rem_shift);
			root_out <= {root_in[RootW-2:0], take};
			s_out    <= s_in;
		end
	end
endmodule

FILE: rtl/sdp_div_cell.sv
// One cell of the restoring divider chain: resolves one quotient bit per stage.
module sdp_div_cell (
	input  logic                      clk,
	input  logic                      en,
	input  logic [5:0]                pos,
	input  logic [sdp_pkg::RootW:0]   rem_in,
	input  logic [sdp_pkg::NumW-1:0]  num_in,
	input  logic [sdp_pkg::RootW-1:0] den_in,
	input  logic [sdp_pkg::QuoW-1:0]  quo_in,
	output logic [sdp_pkg::RootW:0]   rem_out,
	output logic [sdp_pkg::NumW-1:0]  num_out,
	output logic [sdp_pkg::RootW-1:0] den_out,
	output logic [sdp_pkg::QuoW-1:0]  quo_out
);
	import sdp_pkg::*;

	logic [RootW+1:0] part;
	logic             take;

	always_comb begin
		part = {rem_in, num_in[pos]};
		take = part >= {2'b00, den_in};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_out <= take ? (RootW+1)'(part - {2'b00, den_in}) : (RootW+1)'(part);
			num_out <= num_in;
			den_out <= den_in;
			quo_out <= {quo_in[QuoW-2:0], take};
		end
	end
endmodule

FILE: rtl/sdp_checker.sv
// Port-level checker for the spring direction projection block, with its bind.
module sdp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        degenerate,
	input logic [31:0] dir_x,
	input logic [31:0] dir_y,
	input logic [31:0] dir_z
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(dir_x))
		else $error("result changed while stalled");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> dir_x == 0 && dir_y == 0 && dir_z == 0)
		else $error("degenerate result not zero");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> ready)
		else $error("input stalled with empty output");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !ready)
		else $error("input taken while the output is stalled");
endmodule

bind spring_direction_projection sdp_checker u_sdp_checker (
	.clk(clk), .arst_n(arst_n), .ready(ready),
	.out_valid(out_valid), .out_ready(out_ready), .degenerate(degenerate),
	.dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z)
);
